>>> rtl/core/mmhm_pkg.sv
// shared types, constants and defaults for the min/max heat map colorizer
`default_nettype none

package mmhm_pkg;

    localparam int VALUE_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;

    // one color channel and the packed rgb result
    localparam int CH_W        = 8;
    localparam int OUT_TDATA_W = 3 * CH_W;

    // input tuser bit positions
    localparam int TUSER_MODE  = 0;
    localparam int TUSER_FIRST = 1;
    localparam int IN_TUSER_W  = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MAP
    } t_state;

    // request into the divider
    typedef struct packed {
        logic start;
    } t_div_req;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

>>> rtl/core/mmhm_divider.sv
// restoring radix-2 divider, one quotient bit per cycle
`default_nettype none

module mmhm_divider #(
    parameter int VALUE_WIDTH   = mmhm_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = mmhm_pkg::FRACTION_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire mmhm_pkg::t_div_req      i_req,
    input  wire [VALUE_WIDTH-1:0]        i_num,
    input  wire [VALUE_WIDTH-1:0]        i_den,
    output mmhm_pkg::t_div_status        o_status,
    output logic [FRACTION_BITS-1:0]     o_quot
);
    import mmhm_pkg::*;

    localparam int CNT_W = $clog2(FRACTION_BITS);

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic [VALUE_WIDTH-1:0]   r_rem;
    logic [VALUE_WIDTH-1:0]   r_den;
    logic [FRACTION_BITS-1:0] r_quot;

    logic [VALUE_WIDTH:0]     rem_sh;
    logic [VALUE_WIDTH:0]     rem_sub;
    logic                     take;

    // shared subtract and compare
    always_comb begin
        rem_sh  = {r_rem, 1'b0};
        rem_sub = rem_sh - {1'b0, r_den};
        take    = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(FRACTION_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= take ? rem_sub[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
            r_quot <= {r_quot[FRACTION_BITS-2:0], take};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_quot;

endmodule

`default_nettype wire

>>> rtl/core/mmhm_ramp.sv
// three segment red-yellow-green-cyan ramp from a normalized fraction
`default_nettype none

module mmhm_ramp #(
    parameter int FRACTION_BITS = mmhm_pkg::FRACTION_BITS_DEF
) (
    input  wire  [FRACTION_BITS:0]        i_t,
    output logic [mmhm_pkg::CH_W-1:0]     o_red,
    output logic [mmhm_pkg::CH_W-1:0]     o_green,
    output logic [mmhm_pkg::CH_W-1:0]     o_blue
);
    import mmhm_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int BW = F + 2;
    localparam logic [F:0]      ONE_U  = (F+1)'(1) << F;
    localparam logic [BW-1:0]   ONE_B  = BW'(1) << F;
    localparam logic [BW-1:0]   TWO_B  = BW'(2) << F;
    localparam logic [F+9:0]    ROUND  = (F+10)'((1 << F) - 1);
    localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

    logic [F:0]      u;
    logic [BW-1:0]   big;
    logic [BW-1:0]   x_full;
    logic [F:0]      x;
    logic [F+8:0]    p;
    logic [F+9:0]    pc;
    logic [CH_W-1:0] floor_ch;
    logic [CH_W-1:0] ceil_ch;

    always_comb begin
        u   = ONE_U - i_t;
        big = {1'b0, u} + {u, 1'b0};

        if (big < ONE_B) begin
            x_full = big;
        end else if (big < TWO_B) begin
            x_full = big - ONE_B;
        end else begin
            x_full = big - TWO_B;
        end
        x = x_full[F:0];

        // times 255 as shift and subtract
        p        = {x, 8'd0} - {8'd0, x};
        pc       = {1'b0, p} + ROUND;
        floor_ch = p[F+7:F];
        ceil_ch  = pc[F+7:F];

        if (big < ONE_B) begin
            o_red   = CH_MAX;
            o_green = floor_ch;
            o_blue  = '0;
        end else if (big < TWO_B) begin
            o_red   = CH_MAX - ceil_ch;
            o_green = CH_MAX;
            o_blue  = '0;
        end else begin
            o_red   = '0;
            o_green = CH_MAX;
            o_blue  = floor_ch;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/min_max_heat_map_colorizer_top.sv
// top level of the min/max normalized heat map colorizer
`default_nettype none

// Field values come in two passes on the slave stream. A scan request
// (tuser mode bit 0) widens the running minimum/maximum, or restarts the
// range at its own value when the first bit is set; in either case it
// gives no result. A color request (mode bit 1) is normalized against the
// range to t = (value - min) / (max - min) as a FRACTION_BITS fraction,
// inverted, and run through a red -> yellow -> green -> cyan ramp; one rgb
// result leaves on the master stream, with tuser flagging an empty or flat
// range (then the color is cyan). A color request that needs the division
// occupies the block through accept, the one-bit-per-cycle restoring
// divider, quotient pickup and color mapping; a value at or outside the
// range, or an empty or flat range, skips the division and goes from
// accept straight to color mapping. Input is refused meanwhile.
// A finished color sits in the output register until taken, so the next
// request may be accepted while it waits; a further color result stalls in
// the mapping step until the output register frees up.
module min_max_heat_map_colorizer_top #(
    parameter int VALUE_WIDTH   = mmhm_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = mmhm_pkg::FRACTION_BITS_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    // slave stream
    input  wire                                    i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata: value [VALUE_WIDTH-1:0], zero padded to whole bytes
    input  wire  [((VALUE_WIDTH+7)/8)*8-1:0]       i_s_tdata,
    // tuser: mode [0], first [1]
    input  wire  [mmhm_pkg::IN_TUSER_W-1:0]        i_s_tuser,
    // master stream
    output logic                                   o_m_tvalid,
    input  wire                                    i_m_tready,
    // tdata: red [7:0], green [15:8], blue [23:16]
    output logic [mmhm_pkg::OUT_TDATA_W-1:0]       o_m_tdata,
    // tuser: flat_range [0]
    output logic                                   o_m_tuser
);
    import mmhm_pkg::*;

    localparam int F = FRACTION_BITS;
    localparam logic [VALUE_WIDTH-1:0] POS_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] NEG_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [F:0]             T_ONE   = (F+1)'(1) << F;

    t_state r_state;
    t_state n_state;

    // running range
    logic signed [VALUE_WIDTH-1:0] r_low;
    logic signed [VALUE_WIDTH-1:0] r_high;

    // normalized fraction and flat flag for the request at work
    logic [F:0] r_t;
    logic       r_flat;

    // output register
    logic                r_out_valid;
    logic [CH_W-1:0]     r_red;
    logic [CH_W-1:0]     r_green;
    logic [CH_W-1:0]     r_blue;
    logic                r_out_flat;

    logic signed [VALUE_WIDTH-1:0] v;
    logic mode;
    logic first;
    logic in_acc;
    logic low_lt_high;
    logic low_lt_v;
    logic v_lt_high;
    logic out_free;
    logic load_out;

    t_div_req         div_req;
    t_div_status      div_status;
    logic [F-1:0]     div_quot;
    logic [CH_W-1:0]  ramp_red;
    logic [CH_W-1:0]  ramp_green;
    logic [CH_W-1:0]  ramp_blue;

    assign v     = $signed(i_s_tdata[VALUE_WIDTH-1:0]);
    assign mode  = i_s_tuser[TUSER_MODE];
    assign first = i_s_tuser[TUSER_FIRST];

    assign low_lt_high = (r_low < r_high);
    assign low_lt_v    = (r_low < v);
    assign v_lt_high   = (v < r_high);

    assign out_free = !r_out_valid || i_m_tready;

    // sequencer: next state and control
    always_comb begin
        n_state       = r_state;
        o_s_tready    = 1'b0;
        div_req.start = 1'b0;
        load_out      = 1'b0;
        in_acc        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                in_acc     = i_s_tvalid;
                if (i_s_tvalid && mode) begin
                    // strictly inside a proper range needs the divider
                    if (low_lt_high && low_lt_v && v_lt_high) begin
                        div_req.start = 1'b1;
                        n_state       = ST_DIV;
                    end else begin
                        n_state = ST_MAP;
                    end
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // range tracking on scan requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= $signed(POS_MAX);
            r_high <= $signed(NEG_MIN);
        end else if (in_acc && !mode) begin
            if (first) begin
                r_low  <= v;
                r_high <= v;
            end else begin
                if (v < r_low) begin
                    r_low <= v;
                end
                if (r_high < v) begin
                    r_high <= v;
                end
            end
        end
    end

    // fraction setup: flat and clamp cases resolved at accept, quotient taken when the divider is done
    always_ff @(posedge i_clk) begin
        if (in_acc && mode) begin
            r_flat <= !low_lt_high;
            if (!low_lt_high || !low_lt_v) begin
                r_t <= '0;
            end else if (!v_lt_high) begin
                r_t <= T_ONE;
            end else begin
                r_t <= '0;
            end
        end else if (r_state == ST_DIV && div_status.done) begin
            r_t <= {1'b0, div_quot};
        end
    end

    // output register, holds until the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_red      <= ramp_red;
            r_green    <= ramp_green;
            r_blue     <= ramp_blue;
            r_out_flat <= r_flat;
        end
    end

    mmhm_divider #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (div_req),
        .i_num    (VALUE_WIDTH'(v - r_low)),
        .i_den    (VALUE_WIDTH'(r_high - r_low)),
        .o_status (div_status),
        .o_quot   (div_quot)
    );

    mmhm_ramp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ramp (
        .i_t     (r_t),
        .o_red   (ramp_red),
        .o_green (ramp_green),
        .o_blue  (ramp_blue)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_blue, r_green, r_red};
    assign o_m_tuser  = r_out_flat;

endmodule

`default_nettype wire

>>> rtl/core/mmhm_checker.sv
// port level assertions for the heat map colorizer, bound to the top level
`default_nettype none

module mmhm_checker #(
    parameter int VALUE_WIDTH = mmhm_pkg::VALUE_WIDTH_DEF
) (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  i_s_tvalid,
    input wire                                  o_s_tready,
    input wire [mmhm_pkg::IN_TUSER_W-1:0]       i_s_tuser,
    input wire                                  o_m_tvalid,
    input wire                                  i_m_tready,
    input wire [mmhm_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    input wire                                  o_m_tuser
);
    import mmhm_pkg::*;

    logic s_acc;
    assign s_acc = i_s_tvalid && o_s_tready;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // a color request keeps the input closed the next cycle
    a_color_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && i_s_tuser[TUSER_MODE] |=> !o_s_tready)
        else $error("input reopened right after a color request");

    // a scan request never produces a result
    a_scan_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && !i_s_tuser[TUSER_MODE] && !o_m_tvalid |=> !o_m_tvalid)
        else $error("result after a scan request");

    // flat range always shows as cyan
    a_flat_cyan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == {8'hFF, 8'hFF, 8'h00})
        else $error("flat range not cyan");

    // red and blue never light together on the ramp
    a_ramp_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[7:0] == 8'h00 || o_m_tdata[23:16] == 8'h00))
        else $error("red and blue both nonzero");

endmodule

bind min_max_heat_map_colorizer_top mmhm_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_mmhm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

>>> tb/min_max_heat_map_colorizer_top_tb.sv
// testbench for the min/max heat map colorizer: scan/color passes against a built-in predictor
`timescale 1ns / 100ps

module min_max_heat_map_colorizer_top_tb;

    import mmhm_pkg::*;

    localparam int VW      = VALUE_WIDTH_DEF;
    localparam int FB      = FRACTION_BITS_DEF;
    localparam int DATA_W  = ((VW + 7) / 8) * 8;

    // request kinds carried in tuser
    localparam logic MODE_SCAN  = 1'b0;
    localparam logic MODE_COLOR = 1'b1;

    localparam int ITEM_TARGET = 750;
    localparam int QUIET_ITEMS = 100;   // no idling on either side for this many final requests
    localparam int DRAIN_LIMIT = 5000;  // cycles allowed for outstanding colors to drain
    localparam int SETTLE      = 40;    // settle time after draining the colors
    localparam int PRINT_LIMIT = 20;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            flat;
    } t_heat_color;

    // tracks the observed range and the colors still owed by the block
    class heat_map_scoreboard;
        logic signed [VW-1:0] range_lo;
        logic signed [VW-1:0] range_hi;
        t_heat_color          pending_colors[$];
        int unsigned          errors;
        int unsigned          scans;
        int unsigned          colors;
        int unsigned          flats_seen;

        function new();
            range_lo   = {1'b0, {(VW-1){1'b1}}};
            range_hi   = {1'b1, {(VW-1){1'b0}}};
            errors     = 0;
            scans      = 0;
            colors     = 0;
            flats_seen = 0;
        endfunction

        function t_heat_color predict_color(logic signed [VW-1:0] value);
            t_heat_color     c;
            logic [63:0]     unit;
            logic [63:0]     frac;
            logic [63:0]     inv;
            logic [63:0]     big;
            logic [63:0]     prod;
            logic [63:0]     span;
            logic [63:0]     rem;
            logic signed [63:0] lo64;
            logic signed [63:0] hi64;
            logic signed [63:0] v64;
            logic            carry;
            unit   = 64'd1 << FB;
            c      = '0;
            lo64   = range_lo;
            hi64   = range_hi;
            v64    = value;
            if (!(range_lo < range_hi)) begin
                // empty or degenerate range: forced to the cold end
                c.flat = 1'b1;
                frac   = 0;
            end else if (!(range_lo < value)) begin
                frac = 0;
            end else if (!(value < range_hi)) begin
                frac = unit;
            end else begin
                // restoring division, one quotient bit per step
                span = hi64 - lo64;
                rem  = v64 - lo64;
                frac = 0;
                for (int i = 0; i < FB; i++) begin
                    carry = rem[63];
                    rem   = rem << 1;
                    frac  = frac << 1;
                    if (carry || rem >= span) begin
                        rem  = rem - span;
                        frac = frac | 64'd1;
                    end
                end
            end
            inv = unit - frac;
            big = 3 * inv;
            if (big < unit) begin
                c.red   = 8'd255;
                c.green = CH_W'((big * 255) >> FB);
                c.blue  = 8'd0;
            end else if (big < 2 * unit) begin
                prod    = (big - unit) * 255;
                c.red   = CH_W'(255 - ((prod + unit - 1) >> FB));
                c.green = 8'd255;
                c.blue  = 8'd0;
            end else begin
                c.red   = 8'd0;
                c.green = 8'd255;
                c.blue  = CH_W'(((big - 2 * unit) * 255) >> FB);
            end
            return c;
        endfunction

        function void note_request(logic mode, logic first, logic signed [VW-1:0] value);
            if (mode == MODE_SCAN) begin
                scans++;
                if (first) begin
                    range_lo = value;
                    range_hi = value;
                end else begin
                    if (value < range_lo) range_lo = value;
                    if (range_hi < value) range_hi = value;
                end
            end else begin
                colors++;
                pending_colors.push_back(predict_color(value));
            end
        endfunction

        task report_mismatch(string msg);
            if (errors < PRINT_LIMIT) $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        task check_color(t_heat_color got);
            t_heat_color want;
            if (got.flat) flats_seen++;
            if (pending_colors.size() == 0) begin
                report_mismatch($sformatf("unexpected color r=%0d g=%0d b=%0d flat=%0b",
                                          got.red, got.green, got.blue, got.flat));
            end else begin
                want = pending_colors.pop_front();
                if (got.red != want.red)
                    report_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
                if (got.green != want.green)
                    report_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
                if (got.blue != want.blue)
                    report_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
                if (got.flat != want.flat)
                    report_mismatch($sformatf("flat_range %0b, want %0b", got.flat, want.flat));
            end
        endtask
    endclass

    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_s_tvalid = 1'b0;
    logic [DATA_W-1:0]           i_s_tdata  = '0;
    logic [IN_TUSER_W-1:0]       i_s_tuser  = '0;
    logic                        i_m_tready = 1'b0;
    logic                        o_s_tready;
    logic                        o_m_tvalid;
    logic [OUT_TDATA_W-1:0]      o_m_tdata;
    logic                        o_m_tuser;

    heat_map_scoreboard sb;
    int unsigned items_sent   = 0;
    bit          quiet_tail   = 1'b0;
    bit          sender_calm  = 1'b0;
    int unsigned stall_left   = 0;
    int unsigned calm_count   = 0;
    bit          ready_calm   = 1'b0;

    min_max_heat_map_colorizer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // result side: random stall bursts, with calm stretches, none at the tail
    always @(posedge i_clk) begin
        if (calm_count == 0) begin
            ready_calm <= ($urandom_range(0, 2) == 0);
            calm_count <= 100;
        end else begin
            calm_count <= calm_count - 1;
        end
        if (stall_left != 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet_tail && !ready_calm && $urandom_range(0, 4) == 0) begin
            i_m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // result monitor, sampled at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && sb != null && o_m_tvalid && i_m_tready)
            sb.check_color({o_m_tdata[CH_W-1:0], o_m_tdata[2*CH_W-1:CH_W],
                            o_m_tdata[3*CH_W-1:2*CH_W], o_m_tuser});
    end

    task automatic send_request(input logic mode, input logic first,
                                input logic [VW-1:0] value);
        logic [IN_TUSER_W-1:0] user;
        int gap;
        user              = '0;
        user[TUSER_MODE]  = mode;
        user[TUSER_FIRST] = first;
        if (!quiet_tail && !sender_calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= DATA_W'(value);
        i_s_tuser  <= user;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(mode, first, value);
        items_sent++;
        if (items_sent >= ITEM_TARGET - QUIET_ITEMS) quiet_tail = 1'b1;
    endtask

    // hold the sender off until every owed color has been taken or the limit runs out
    task automatic drain_colors(input int unsigned limit);
        int unsigned waited;
        waited = 0;
        i_s_tvalid <= 1'b0;
        while (sb.pending_colors.size() != 0 && waited < limit) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // color value: mostly inside the current range, sometimes at its ends or anywhere
    function automatic logic [VW-1:0] pick_color_value();
        logic [63:0] span;
        int          pick;
        pick = $urandom_range(0, 15);
        if (sb.range_lo <= sb.range_hi && pick < 11) begin
            span = 64'(sb.range_hi) - 64'(sb.range_lo) + 64'd1;
            return VW'(64'(sb.range_lo) + ({$urandom, $urandom} % span));
        end else if (pick == 11) begin
            return sb.range_lo;
        end else if (pick == 12) begin
            return sb.range_hi;
        end
        return VW'($urandom);
    endfunction

    initial begin
        int unsigned n_scan;
        int unsigned n_color;
        int unsigned spread;
        logic [VW-1:0] base;
        logic [VW-1:0] value;
        bit          first;
        bit          wide;

        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty range straight after reset, first bit ignored on color
        send_request(MODE_COLOR, 1'b0, 32'h0000_0000);
        send_request(MODE_COLOR, 1'b1, 32'h0000_3039);
        // single-value range gives a flat result
        send_request(MODE_SCAN,  1'b1, 32'h0001_0000);
        send_request(MODE_COLOR, 1'b0, 32'h0001_0000);
        send_request(MODE_COLOR, 1'b0, 32'hFFFB_0000);
        // range 1.0 .. 5.0: ends, outside, middle, near the segment borders
        send_request(MODE_SCAN,  1'b0, 32'h0005_0000);
        send_request(MODE_COLOR, 1'b0, 32'h0001_0000);
        send_request(MODE_COLOR, 1'b0, 32'h0005_0000);
        send_request(MODE_COLOR, 1'b0, 32'h0000_0000);
        send_request(MODE_COLOR, 1'b1, 32'h7FFF_FFFF);
        send_request(MODE_COLOR, 1'b0, 32'h0003_0000);
        send_request(MODE_COLOR, 1'b0, 32'h0002_5555);
        send_request(MODE_COLOR, 1'b0, 32'h0003_AAAB);
        // full signed range
        send_request(MODE_SCAN,  1'b1, 32'h8000_0000);
        send_request(MODE_SCAN,  1'b0, 32'h7FFF_FFFF);
        send_request(MODE_COLOR, 1'b0, 32'h8000_0001);
        send_request(MODE_COLOR, 1'b0, 32'h7FFF_FFFE);
        send_request(MODE_COLOR, 1'b0, 32'h0000_0000);
        send_request(MODE_SCAN,  1'b0, 32'h8000_0000);
        // two-value range near zero, widened downward without a restart
        send_request(MODE_SCAN,  1'b1, 32'hFFFF_FFFF);
        send_request(MODE_SCAN,  1'b0, 32'hFFFF_FFFE);
        send_request(MODE_COLOR, 1'b0, 32'hFFFF_FFFF);
        send_request(MODE_COLOR, 1'b0, 32'hFFFF_FFFE);

        drain_colors(DRAIN_LIMIT);

        // random passes: mostly a restarted scan followed by colors
        while (items_sent < ITEM_TARGET) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            n_scan  = $urandom_range(1, 8);
            n_color = $urandom_range(1, 12);
            case ($urandom_range(0, 4))
                0:       spread = 0;
                1:       spread = 3;
                2:       spread = 1000;
                3:       spread = 1 << 20;
                default: spread = 32'hFFFF_FFFF;
            endcase
            wide = (spread == 32'hFFFF_FFFF);
            base = $urandom;
            if ($urandom_range(0, 9) != 0) begin
                for (int i = 0; i < n_scan; i++) begin
                    first = (i == 0) || ($urandom_range(0, 19) == 0);
                    value = wide ? VW'($urandom) : VW'(base + ($urandom % (spread + 1)));
                    send_request(MODE_SCAN, first, value);
                end
            end else begin
                // noise: stray scans that only widen whatever range is there
                for (int i = 0; i < n_scan; i++)
                    send_request(MODE_SCAN, 1'b0, VW'($urandom));
            end
            for (int i = 0; i < n_color; i++)
                send_request(MODE_COLOR, 1'($urandom_range(0, 1)), pick_color_value());
        end

        drain_colors(DRAIN_LIMIT);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.pending_colors.size() != 0)
            sb.report_mismatch($sformatf("%0d colors never arrived", sb.pending_colors.size()));

        $display("covered %0d scan and %0d color requests, %0d flat-range colors seen",
                 sb.scans, sb.colors, sb.flats_seen);
        $display("ranges from single values to the full signed span, %0d mismatches", sb.errors);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout waiting for the block");
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> min_max_heat_map_colorizer_top.f
rtl/core/mmhm_pkg.sv
rtl/core/mmhm_divider.sv
rtl/core/mmhm_ramp.sv
rtl/core/min_max_heat_map_colorizer_top.sv
rtl/core/mmhm_checker.sv
tb/min_max_heat_map_colorizer_top_tb.sv
